[rtl/sctl_pkg.sv]
// ----------------------------------------------------------------------------
// sctl_pkg: shared constants for the sector cache tag lookup
// Widths, reset values, register indexes and the cell compare bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package sctl_pkg;
    localparam int SLOTS_DEF  = 32;
    localparam int LBA_W      = 32;
    localparam int SLOT_OUT_W = 5;
    localparam int CYL_W      = 16;
    localparam int HEAD_W     = 8;
    localparam int SPT_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS = 1'd1;

    localparam logic [SPT_W-1:0]  SPT_RESET   = 6'd18;
    localparam logic [HEAD_W-1:0] HEADS_RESET = 8'd2;

    // Search token passed along the chain of cells.
    typedef struct packed {
        logic             busy;
        logic [LBA_W-1:0] lba;
        logic             hit;
        logic             free_found;
    } scan_t;
endpackage
`default_nettype wire

[rtl/sctl_cell.sv]
// ----------------------------------------------------------------------------
// sctl_cell: one cache slot
// Holds a tag and valid bit; compares the passing search token and forwards.
// ----------------------------------------------------------------------------
`default_nettype none
module sctl_cell
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sctl_pkg::scan_t          scan_in,
    input  wire logic                     wr_en,
    input  wire logic [sctl_pkg::LBA_W-1:0] wr_tag,
    output sctl_pkg::scan_t               scan_out,
    output logic                          match,
    output logic                          free_here
);
    logic [sctl_pkg::LBA_W-1:0] tag_reg;
    logic                       valid_reg;
    sctl_pkg::scan_t            scan_reg;
    sctl_pkg::scan_t            scan_next;

    // Hit and first-free are seen only at the cell where they first occur.
    assign match     = scan_in.busy && !scan_in.hit && valid_reg && (tag_reg == scan_in.lba);
    assign free_here = scan_in.busy && !scan_in.free_found && !valid_reg;

    always_comb
    begin
        scan_next            = scan_in;
        scan_next.hit        = scan_in.hit | match;
        scan_next.free_found = scan_in.free_found | free_here;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (wr_en)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tag_reg <= wr_tag;
    end

    assign scan_out = scan_reg;
endmodule
`default_nettype wire

[rtl/sctl_div.sv]
// ----------------------------------------------------------------------------
// sctl_div: serial restoring divider
// One quotient bit per cycle; zero divisor gives all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module sctl_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [sctl_pkg::LBA_W-1:0] dividend,
    input  wire logic [sctl_pkg::HEAD_W-1:0] divisor,
    output logic                            done,
    output logic [sctl_pkg::LBA_W-1:0]      quotient,
    output logic [sctl_pkg::HEAD_W-1:0]     remainder
);
    localparam int CNT_W = $clog2(sctl_pkg::LBA_W + 1);
    logic [sctl_pkg::LBA_W-1:0]  q_reg, q_next;
    logic [sctl_pkg::HEAD_W:0]   r_reg, r_next;
    logic [sctl_pkg::HEAD_W-1:0] d_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [sctl_pkg::HEAD_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg[sctl_pkg::HEAD_W-1:0], q_reg[sctl_pkg::LBA_W-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = CNT_W'(sctl_pkg::LBA_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // Shift in next dividend bit, subtract when it fits.
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[sctl_pkg::LBA_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[sctl_pkg::LBA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[sctl_pkg::HEAD_W-1:0];
endmodule
`default_nettype wire

[rtl/sector_cache_tag_lookup_chs.sv]
// ----------------------------------------------------------------------------
// sector_cache_tag_lookup_chs: fully associative sector tag cache with CHS
// Hit or sector zero goes from the scan straight to the result; a miss runs two
// divisions in turn on the shared serial divider (sectors per track, then heads).
// The search token walks the chain of slot cells, one cell per cycle, so the
// scan length is set by SLOTS; one transaction is in flight at a time.
// Reset clears all valid bits, the eviction pointer and loads default geometry.
// ----------------------------------------------------------------------------
`default_nettype none
module sector_cache_tag_lookup_chs
#(
    parameter int SLOTS = sctl_pkg::SLOTS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sctl_pkg::LBA_W-1:0]      logical_sector,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output logic [sctl_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic [sctl_pkg::CYL_W-1:0]           cylinder,
    output logic [sctl_pkg::HEAD_W-1:0]          head,
    output logic [sctl_pkg::SPT_W-1:0]           track_sector,
    input  wire logic                            cfg_we,
    input  wire logic [sctl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sctl_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_DIV2 = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [sctl_pkg::SPT_W-1:0] SPT_ONE = 6'd1;

    logic [2:0]                    state_reg, state_next;
    logic [sctl_pkg::SPT_W-1:0]    spt_reg;
    logic [sctl_pkg::HEAD_W-1:0]   heads_reg;
    logic [SW-1:0]                 evict_reg;
    logic [sctl_pkg::LBA_W-1:0]    lba_reg;
    logic                          hit_reg;
    logic [SW-1:0]                 hit_slot_reg;
    logic                          free_reg;
    logic [SW-1:0]                 free_slot_reg;
    logic [SW-1:0]                 res_slot_reg;
    logic [sctl_pkg::CYL_W-1:0]    cyl_reg;
    logic [sctl_pkg::HEAD_W-1:0]   head_reg;
    logic [sctl_pkg::SPT_W-1:0]    ts_reg;

    sctl_pkg::scan_t               chain [SLOTS+1];
    logic [SLOTS-1:0]              match_vec, free_vec, wr_vec;
    logic                          alloc;
    logic [SW-1:0]                 alloc_slot;

    logic                          div_start, div_done;
    logic [sctl_pkg::LBA_W-1:0]    div_n, div_q;
    logic [sctl_pkg::HEAD_W-1:0]   div_d, div_r;

    logic                          in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Inject the search token at the head of the chain: busy, lba, hit, free.
    assign chain[0] = {in_acc, logical_sector, 1'b0, 1'b0};

    // The scan ends when the token leaves the last cell.
    logic scan_end;
    assign scan_end = chain[SLOTS].busy;
    assign alloc    = scan_end && !(hit_reg);
    assign alloc_slot = free_reg ? free_slot_reg : evict_reg;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            assign wr_vec[g] = alloc && (alloc_slot == SW'(g));
            sctl_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .scan_in   (chain[g]),
                .wr_en     (wr_vec[g]),
                .wr_tag    (lba_reg),
                .scan_out  (chain[g+1]),
                .match     (match_vec[g]),
                .free_here (free_vec[g])
            );
        end
    endgenerate

    // Only one cell sees the token each cycle; record which cell it is.
    logic [SW-1:0] pos_reg;

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_n      = lba_reg;
        div_d      = {2'b00, spt_reg};
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_SCAN;
            ST_SCAN:
                if (scan_end)
                begin
                    if (hit_reg || lba_reg == '0)
                        state_next = ST_OUT;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            ST_DIV1:
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_n      = div_q;
                    div_d      = heads_reg;
                    state_next = ST_DIV2;
                end
            ST_DIV2: if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_acc) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            spt_reg   <= sctl_pkg::SPT_RESET;
            heads_reg <= sctl_pkg::HEADS_RESET;
            evict_reg <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == sctl_pkg::REG_SPT)
                    spt_reg <= cfg_data[sctl_pkg::SPT_W-1:0];
                else if (cfg_index == sctl_pkg::REG_HEADS)
                    heads_reg <= cfg_data;
            end
            if (in_acc)
            begin
                // Cell zero compares in the accepting cycle.
                hit_reg  <= match_vec[0];
                free_reg <= free_vec[0];
                pos_reg  <= SW'(1);
            end
            else if (state_reg == ST_SCAN && !scan_end)
            begin
                // Advance with the token; flag first hit and first free slot.
                if (|match_vec) hit_reg <= 1'b1;
                if (|free_vec)  free_reg <= 1'b1;
                pos_reg <= pos_reg + 1'b1;
            end
            if (alloc && !free_reg)
                evict_reg <= (evict_reg == SW'(SLOTS - 1)) ? '0 : evict_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            lba_reg <= logical_sector;
        if (in_acc)
        begin
            if (match_vec[0]) hit_slot_reg  <= '0;
            if (free_vec[0])  free_slot_reg <= '0;
        end
        else if (state_reg == ST_SCAN && !scan_end)
        begin
            if (|match_vec && !hit_reg)  hit_slot_reg  <= pos_reg;
            if (|free_vec && !free_reg)  free_slot_reg <= pos_reg;
        end
        if (scan_end)
        begin
            res_slot_reg <= hit_reg ? hit_slot_reg : alloc_slot;
            cyl_reg      <= '0;
            head_reg     <= '0;
            ts_reg       <= hit_reg ? '0 : SPT_ONE;
        end
        if (state_reg == ST_DIV1 && div_done)
            ts_reg <= div_r[sctl_pkg::SPT_W-1:0] + 1'b1;
        if (state_reg == ST_DIV2 && div_done)
        begin
            cyl_reg  <= div_q[sctl_pkg::CYL_W-1:0];
            head_reg <= div_r;
        end
    end

    sctl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_n),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_valid    = (state_reg == ST_OUT);
    assign hit          = hit_reg;
    assign slot_index   = sctl_pkg::SLOT_OUT_W'(res_slot_reg);
    assign cylinder     = cyl_reg;
    assign head         = head_reg;
    assign track_sector = ts_reg;

`ifndef SYNTHESIS
    a_hit_no_chs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> cylinder == '0 && head == '0 && track_sector == '0)
        else $error("hit result carries CHS");
    a_miss_ts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> track_sector != '0 || spt_reg == '0 || spt_reg == 6'd1)
        else $error("miss sector zero");
    a_single_wr: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_vec))
        else $error("multiple slot writes");
`endif
endmodule
`default_nettype wire

[tb/tb_sector_cache_tag_lookup_chs.sv]
// ----------------------------------------------------------------------------
// Sector cache tag lookup testbench
// Drives logical sector numbers into the tag cache, predicts hit/slot and the
// CHS translation with a local cache image, and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sector_cache_tag_lookup_chs;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic                        hit;
        logic [4:0]                  slot;
        logic [sctl_pkg::CYL_W-1:0]  cyl;
        logic [sctl_pkg::HEAD_W-1:0] hd;
        logic [sctl_pkg::SPT_W-1:0]  sec;
    } chs_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [sctl_pkg::LBA_W-1:0] logical_sector = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [sctl_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [sctl_pkg::CYL_W-1:0] cylinder;
    logic [sctl_pkg::HEAD_W-1:0] head;
    logic [sctl_pkg::SPT_W-1:0] track_sector;
    logic cfg_we = 1'b0;
    logic [sctl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [sctl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Local image of the cache and geometry.
    logic [31:0] tag_img [NSLOT];
    logic        valid_img [NSLOT];
    logic [4:0]  victim_ptr;
    logic [31:0] geo_spt;
    logic [31:0] geo_heads;

    chs_result_t pending_lookups[$];
    int mismatch_count = 0;
    longint cycle_count = 0;
    // Recently used sectors, fed back to provoke hits.
    logic [31:0] recent_lba[$];

    sector_cache_tag_lookup_chs dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if the traffic ever hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sector_cache_tag_lookup_chs test failed");
            $finish;
        end
    end

    // Serial divider convention: zero divisor gives all ones / dividend.
    function automatic logic [31:0] quot(logic [31:0] n, logic [31:0] d);
        return (d == 0) ? 32'hFFFF_FFFF : n / d;
    endfunction

    function automatic logic [31:0] remn(logic [31:0] n, logic [31:0] d);
        return (d == 0) ? n : n % d;
    endfunction

    // Predict one lookup and update the cache image.
    function automatic chs_result_t lookup_sector(logic [31:0] lba);
        chs_result_t r;
        int victim;
        logic [31:0] trk;
        r = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (valid_img[i] && tag_img[i] == lba)
            begin
                r.hit = 1'b1;
                r.slot = i[4:0];
                return r;
            end
        end
        victim = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (victim < 0 && !valid_img[i])
                victim = i;
        end
        if (victim < 0)
        begin
            victim = victim_ptr;
            victim_ptr = victim_ptr + 5'd1;
        end
        tag_img[victim] = lba;
        valid_img[victim] = 1'b1;
        r.slot = victim[4:0];
        if (lba == 0)
        begin
            r.sec = 6'd1;
        end
        else
        begin
            trk = quot(lba, geo_spt);
            r.sec = sctl_pkg::SPT_W'(remn(lba, geo_spt) + 1);
            r.hd = sctl_pkg::HEAD_W'(remn(trk, geo_heads));
            r.cyl = sctl_pkg::CYL_W'(quot(trk, geo_heads));
        end
        return r;
    endfunction

    // Receiver: stall on its own pattern, check each transaction.
    initial
    begin : result_checker
        chs_result_t exp_r;
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_lookups.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result slot=%0d", slot_index);
                end
                else
                begin
                    exp_r = pending_lookups.pop_front();
                    if (hit !== exp_r.hit || slot_index !== exp_r.slot
                        || cylinder !== exp_r.cyl || head !== exp_r.hd
                        || track_sector !== exp_r.sec)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch exp %0d/%0d %0d:%0d:%0d got %0d/%0d %0d:%0d:%0d",
                                exp_r.hit, exp_r.slot, exp_r.cyl, exp_r.hd, exp_r.sec,
                                hit, slot_index, cylinder, head, track_sector);
                    end
                end
            end
            // Switch the stall pattern now and then; one mode never stalls.
            if ($urandom_range(0, 199) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Send one transaction, with a random gap first when burst runs out.
    int burst_left = 0;
    task automatic send_sector(logic [31:0] lba);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        logical_sector <= lba;
        do
            @(posedge clk);
        while (in_stall);
        pending_lookups.push_back(lookup_sector(lba));
        in_valid <= 1'b0;
        // Step past the accepting edge so the next drive lands in a new time step.
        @(posedge clk);
    endtask

    // Wait for idle, then write both geometry registers.
    task automatic set_geometry(logic [7:0] spt, logic [7:0] heads);
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sctl_pkg::REG_SPT;
        cfg_data <= spt;
        @(posedge clk);
        cfg_index <= sctl_pkg::REG_HEADS;
        cfg_data <= heads;
        @(posedge clk);
        cfg_we <= 1'b0;
        geo_spt = spt & 8'h3F;
        geo_heads = heads;
    endtask

    function automatic logic [31:0] random_lba();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return (recent_lba.size() > 0)
                ? recent_lba[$urandom_range(0, recent_lba.size() - 1)] : 0;
            3: return (recent_lba.size() > 0)
                ? recent_lba[$urandom_range(0, recent_lba.size() - 1)] : 1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed_extremes();
        // Extremes of the sector field, zero sector, repeats for hits.
        send_sector(32'd0);
        send_sector(32'd0);
        send_sector(32'hFFFF_FFFF);
        send_sector(32'hFFFF_FFFE);
        send_sector(32'hFFFF_FFFF);
        send_sector(32'd1);
        send_sector(32'd17);
        send_sector(32'd18);
        send_sector(32'd35);
        send_sector(32'd36);
        send_sector(32'h5555_5555);
        send_sector(32'hAAAA_AAAA);
        send_sector(32'h0000_0001);
    endtask

    task automatic test_eviction_wrap();
        // Fill every slot and force round-robin eviction past wrap.
        for (int i = 0; i < 70; i++)
            send_sector(32'h1000 + i);
        send_sector(32'h1000 + 69);
    endtask

    task automatic test_geometry_corners();
        set_geometry(8'd1, 8'd1);
        send_sector(32'hFFFF_FFF0);
        send_sector(32'd12345);
        set_geometry(8'd63, 8'd255);
        send_sector(32'hFFFF_FFF1);
        send_sector(32'd99999);
        set_geometry(8'd0, 8'd0);
        send_sector(32'd777);
        send_sector(32'd0);
        set_geometry(8'hC5, 8'd16);
        send_sector(32'd778);
    endtask

    task automatic test_random_traffic(int count);
        logic [31:0] lba;
        for (int i = 0; i < count; i++)
        begin
            if (i % 400 == 399)
                set_geometry($urandom_range(0, 255), $urandom_range(0, 255));
            lba = random_lba();
            recent_lba.push_back(lba);
            if (recent_lba.size() > 40)
                void'(recent_lba.pop_front());
            send_sector(lba);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            tag_img[i] = '0;
            valid_img[i] = 1'b0;
        end
        victim_ptr = '0;
        geo_spt = sctl_pkg::SPT_RESET;
        geo_heads = sctl_pkg::HEADS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_eviction_wrap();
        test_geometry_corners();
        set_geometry(8'd18, 8'd2);
        test_random_traffic(1550);
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("sector_cache_tag_lookup_chs test passed");
        else
            $display("sector_cache_tag_lookup_chs test failed");
        $finish;
    end
endmodule
`default_nettype wire
